// ===== rtl/gyro_yaw_integrator_defines.svh =====
// ----------------------------------------------------------------------------
// Gyro yaw integrator: assertion macros
// Concurrent checks on the rising edge of clk, quiet while rst is high.
// ----------------------------------------------------------------------------
`ifndef GYRO_YAW_INTEGRATOR_DEFINES_SVH
`define GYRO_YAW_INTEGRATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define GYI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define GYI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GYI_ASSERT_IMP(lbl, ante, cons, msg)
`define GYI_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/gyi_pkg.sv =====
// ----------------------------------------------------------------------------
// Gyro yaw integrator package
// Widths, scale constants, register indexes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gyi_pkg;

  localparam int DATA_W      = 32;
  localparam int CAL_SAMPLES = 100;
  localparam int CAL_HALF    = CAL_SAMPLES / 2;
  localparam int CNT_W       = 13;
  localparam int SUM_W       = 48;
  localparam int REM_W       = $clog2(CAL_SAMPLES) + 1;
  localparam int ACC_W       = 68;
  localparam int MPL_W       = 32;
  localparam int RATE_W      = 34;
  localparam int FRAC        = 28;
  localparam int NUM_COEF    = 7;
  localparam int HIST        = 4;

  localparam logic [MPL_W-1:0] DEG2RAD_Q32   = 32'd74960064;
  localparam logic [MPL_W-1:0] YAW_SCALE_Q32 = 32'd44798134;
  localparam logic [DATA_W-1:0] FIRST_DT_US  = 32'd10000;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sh7FFFFFFF);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sh80000000);

  typedef enum logic [2:0] {
    REG_B0 = 3'd0,
    REG_B2 = 3'd1,
    REG_B4 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4,
    REG_A3 = 3'd5,
    REG_A4 = 3'd6,
    REG_NONE = 3'd7
  } reg_idx_t;

  // command to the serial multiply-accumulate unit
  typedef struct packed {
    logic                    start;
    logic                    load;
    logic signed [ACC_W-1:0] init;
    logic signed [ACC_W-1:0] mcand;
    logic [MPL_W-1:0]        mplier;
  } mac_cmd_t;

  // clamp a wide signed value to the 32-bit signed range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[DATA_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gyi_sample_if.sv =====
// ----------------------------------------------------------------------------
// Gyro sample channel
// Valid/ready channel carrying one rate sample and its timestamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gyi_sample_if import gyi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] gyro_rate;
  logic [DATA_W-1:0]        time_stamp;

  modport source (output valid, output gyro_rate, output time_stamp, input ready);
  modport sink (input valid, input gyro_rate, input time_stamp, output ready);
endinterface

`default_nettype wire

// ===== rtl/gyi_result_if.sv =====
// ----------------------------------------------------------------------------
// Yaw result channel
// Valid/ready channel carrying yaw, filtered rate, calibration flag and bias.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gyi_result_if import gyi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] yaw_angle;
  logic signed [DATA_W-1:0] filtered_rate;
  logic                     calibrating;
  logic signed [DATA_W-1:0] bias_value;

  modport source (output valid, output yaw_angle, output filtered_rate,
                  output calibrating, output bias_value, input ready);
  modport sink (input valid, input yaw_angle, input filtered_rate,
                input calibrating, input bias_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/gyi_serial_mac.sv =====
// ----------------------------------------------------------------------------
// Bit-serial multiply-accumulate
// Adds mcand * mplier (both two's complement) to the accumulator, one
// multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gyi_serial_mac import gyi_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire mac_cmd_t                cmd,
  output logic                         busy,
  output logic                         done,
  output logic signed [ACC_W-1:0]      acc
);

  localparam int BIT_CNT_W = $clog2(MPL_W);

  logic signed [ACC_W-1:0] mcand_sh;
  logic [MPL_W-1:0]        mplier_sh;
  logic [BIT_CNT_W-1:0]    bit_cnt;
  logic signed [ACC_W-1:0] term;
  logic                    last_bit;
  logic signed [ACC_W-1:0] acc_next;

  // the sign bit of the multiplier carries negative weight
  assign last_bit = (bit_cnt == BIT_CNT_W'(MPL_W - 1));
  assign term     = mplier_sh[0] ? mcand_sh : '0;
  assign acc_next = last_bit ? (acc - term) : (acc + term);

  // sequence the bit count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy    <= 1'b1;
        bit_cnt <= '0;
      end else if (busy) begin
        bit_cnt <= bit_cnt + 1'b1;
        if (last_bit) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift operands and accumulate
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mcand_sh  <= cmd.mcand;
      mplier_sh <= cmd.mplier;
      if (cmd.load) begin
        acc <= cmd.init;
      end
    end else if (busy) begin
      acc       <= acc_next;
      mcand_sh  <= mcand_sh <<< 1;
      mplier_sh <= mplier_sh >> 1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gyi_serial_div.sv =====
// ----------------------------------------------------------------------------
// Bit-serial divider by the calibration length
// Restoring division of an unsigned dividend by CAL_SAMPLES, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gyi_serial_div import gyi_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  output logic                  done,
  output logic [SUM_W-1:0]      quot
);

  localparam int DIV_CNT_W = $clog2(SUM_W);
  localparam logic [REM_W:0] DIVISOR = (REM_W + 1)'(CAL_SAMPLES);

  logic                 busy;
  logic [DIV_CNT_W-1:0] bit_cnt;
  logic [REM_W-1:0]     rem;
  logic [SUM_W-1:0]     dvd_sh;
  logic [REM_W:0]       trial;
  logic                 fits;

  assign trial = {rem, dvd_sh[SUM_W-1]};
  assign fits  = (trial >= DIVISOR);

  // count quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        bit_cnt <= '0;
      end else if (busy) begin
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_cnt == DIV_CNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // subtract the divisor where it fits, shift in one quotient bit
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      dvd_sh <= dividend;
    end else if (busy) begin
      rem    <= fits ? REM_W'(trial - DIVISOR) : trial[REM_W-1:0];
      dvd_sh <= dvd_sh << 1;
      quot   <= {quot[SUM_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gyro_yaw_integrator.sv =====
// ----------------------------------------------------------------------------
// Gyro yaw integrator
// Bias calibration, band-pass IIR and yaw integration of gyro z-rate samples.
// ----------------------------------------------------------------------------
// Usage:
//   sample carries one gyro z-rate (Q16.16 deg/s) and a microsecond stamp;
//   result returns one transaction per sample: yaw binary angle, band-passed
//   rate, the calibration flag and the bias. Filter coefficients are written
//   through cfg_we / cfg_index / cfg_data while the block is idle.
//   All products run through one bit-serial multiply-accumulate unit, one
//   multiplier bit a cycle. A calibration sample needs the rate product (and
//   the divider on the last one); a filtered sample needs the rate product
//   and one product per filter coefficient, plus the time-step and yaw
//   products when the time step is positive. One sample is worked on at a
//   time; sample.ready is high only while the sequencer waits for input.
//   The result register decouples the sides: the next sample is taken while
//   a result still waits, and the sequencer holds the following result until
//   the receiver takes the earlier one.
//   Reset (rst, synchronous) restores the default coefficients, clears the
//   filter history, yaw and bias and starts a new calibration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "gyro_yaw_integrator_defines.svh"

module gyro_yaw_integrator import gyi_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  gyi_sample_if.sink             sample,
  gyi_result_if.source           result,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [DATA_W-1:0] cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RATE   = 7'b0000010,
    S_CALDIV = 7'b0000100,
    S_FILT   = 7'b0001000,
    S_DT     = 7'b0010000,
    S_YAW    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state;
  logic   launch;

  logic signed [DATA_W-1:0] coef [NUM_COEF];
  logic signed [DATA_W-1:0] in_hist [HIST];
  logic signed [DATA_W-1:0] out_hist [HIST];

  logic signed [DATA_W-1:0] gyro;
  logic [DATA_W-1:0]        stamp;
  logic signed [RATE_W-1:0] x_val;
  logic signed [DATA_W-1:0] y_val;
  logic signed [DATA_W-1:0] dt;
  logic signed [63:0]       q_val;
  logic [2:0]               fidx;
  logic                     was_cal;

  logic [DATA_W-1:0]        yaw;
  logic signed [DATA_W-1:0] bias;
  logic signed [SUM_W-1:0]  cal_sum;
  logic [CNT_W-1:0]         cal_count;
  logic                     cal_active;
  logic                     first_sample;
  logic [DATA_W-1:0]        last_stamp;

  logic                     out_valid;
  logic                     out_load;
  logic [DATA_W-1:0]        out_yaw;
  logic signed [DATA_W-1:0] out_rate;
  logic                     out_cal;
  logic signed [DATA_W-1:0] out_bias;

  mac_cmd_t                 mac_cmd;
  logic                     mac_busy;
  logic                     mac_done;
  logic signed [ACC_W-1:0]  mac_acc;

  logic                     div_start;
  logic                     div_done;
  logic [SUM_W-1:0]         div_quot;
  logic [SUM_W-1:0]         div_dvd;

  logic signed [RATE_W-1:0] rate_new;
  logic signed [RATE_W-1:0] x_new;
  logic signed [DATA_W-1:0] y_new;
  logic signed [DATA_W-1:0] dt_new;
  logic                     dt_pos;
  logic [CNT_W-1:0]         count_inc;
  logic signed [SUM_W-1:0]  cal_sum_abs;
  logic signed [ACC_W-1:0]  mean_signed;
  logic signed [DATA_W-1:0] bias_new;
  logic signed [ACC_W-1:0]  filt_operand;

  gyi_serial_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mac_cmd),
    .busy (mac_busy),
    .done (mac_done),
    .acc  (mac_acc)
  );

  gyi_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .done     (div_done),
    .quot     (div_quot)
  );

  // derived values of the current step
  assign rate_new    = mac_acc[32 +: RATE_W];
  assign x_new       = rate_new - RATE_W'(bias);
  assign y_new       = sat32(mac_acc >>> FRAC);
  assign dt_new      = first_sample ? FIRST_DT_US : (stamp - last_stamp);
  assign dt_pos      = !dt_new[DATA_W-1] && (dt_new != '0);
  assign count_inc   = cal_count + 1'b1;
  assign cal_sum_abs = cal_sum[SUM_W-1] ? -cal_sum : cal_sum;
  assign div_dvd     = cal_sum_abs + SUM_W'(CAL_HALF);
  assign mean_signed = cal_sum[SUM_W-1] ? -ACC_W'(div_quot) : ACC_W'(div_quot);
  assign bias_new    = sat32(mean_signed);
  assign div_start   = launch && (state == S_CALDIV);
  assign out_load    = (state == S_OUT) && (!out_valid || result.ready);

  // pick the filter operand for this product
  always_comb begin
    case (fidx)
      3'd0:    filt_operand = ACC_W'(x_val);
      3'd1:    filt_operand = ACC_W'(in_hist[1]);
      3'd2:    filt_operand = ACC_W'(in_hist[3]);
      default: filt_operand = -ACC_W'(out_hist[2'(fidx - 3'd3)]);
    endcase
  end

  // drive the multiply-accumulate command
  always_comb begin
    mac_cmd        = '0;
    mac_cmd.start  = launch && (state != S_CALDIV);
    case (state)
      S_RATE: begin
        mac_cmd.load   = 1'b1;
        mac_cmd.init   = ACC_W'(64'sh80000000);
        mac_cmd.mcand  = -ACC_W'(gyro);
        mac_cmd.mplier = DEG2RAD_Q32;
      end
      S_FILT: begin
        mac_cmd.load   = (fidx == 3'd0);
        mac_cmd.init   = ACC_W'(64'sd1) <<< (FRAC - 1);
        mac_cmd.mcand  = filt_operand;
        mac_cmd.mplier = coef[fidx];
      end
      S_DT: begin
        mac_cmd.load   = 1'b1;
        mac_cmd.mcand  = ACC_W'(y_val);
        mac_cmd.mplier = dt;
      end
      S_YAW: begin
        mac_cmd.load   = 1'b1;
        mac_cmd.init   = ACC_W'(64'sh80000000);
        mac_cmd.mcand  = ACC_W'(q_val);
        mac_cmd.mplier = YAW_SCALE_Q32;
      end
      default: begin
        mac_cmd.load = 1'b0;
      end
    endcase
  end

  // write filter coefficients
  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0] <= 32'sd12509092;
      coef[1] <= -32'sd25018184;
      coef[2] <= 32'sd12509092;
      coef[3] <= -32'sd834780581;
      coef[4] <= 32'sd993103813;
      coef[5] <= -32'sd538588899;
      coef[6] <= 32'sd115588308;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_B0:  coef[0] <= cfg_data;
        REG_B2:  coef[1] <= cfg_data;
        REG_B4:  coef[2] <= cfg_data;
        REG_A1:  coef[3] <= cfg_data;
        REG_A2:  coef[4] <= cfg_data;
        REG_A3:  coef[5] <= cfg_data;
        REG_A4:  coef[6] <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequence one sample through rate, calibration, filter and yaw
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      launch       <= 1'b0;
      fidx         <= '0;
      yaw          <= '0;
      bias         <= '0;
      cal_sum      <= '0;
      cal_count    <= '0;
      cal_active   <= 1'b1;
      first_sample <= 1'b1;
      last_stamp   <= '0;
      for (int i = 0; i < HIST; i++) begin
        in_hist[i]  <= '0;
        out_hist[i] <= '0;
      end
    end else begin
      launch <= 1'b0;
      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            gyro   <= sample.gyro_rate;
            stamp  <= sample.time_stamp;
            launch <= 1'b1;
            state  <= S_RATE;
          end
        end
        S_RATE: begin
          if (mac_done) begin
            was_cal <= cal_active;
            if (cal_active) begin
              y_val     <= '0;
              cal_sum   <= cal_sum + SUM_W'(rate_new);
              cal_count <= count_inc;
              if (count_inc >= CNT_W'(CAL_SAMPLES)) begin
                launch <= 1'b1;
                state  <= S_CALDIV;
              end else begin
                state <= S_OUT;
              end
            end else begin
              x_val  <= x_new;
              fidx   <= '0;
              launch <= 1'b1;
              state  <= S_FILT;
            end
          end
        end
        S_CALDIV: begin
          if (div_done) begin
            bias       <= bias_new;
            cal_active <= 1'b0;
            state      <= S_OUT;
          end
        end
        S_FILT: begin
          if (mac_done) begin
            if (fidx == 3'd6) begin
              y_val <= y_new;
              for (int i = HIST - 1; i > 0; i--) begin
                in_hist[i]  <= in_hist[i-1];
                out_hist[i] <= out_hist[i-1];
              end
              in_hist[0]   <= sat32(ACC_W'(x_val));
              out_hist[0]  <= y_new;
              dt           <= dt_new;
              first_sample <= 1'b0;
              last_stamp   <= stamp;
              if (dt_pos) begin
                launch <= 1'b1;
                state  <= S_DT;
              end else begin
                state <= S_OUT;
              end
            end else begin
              fidx   <= fidx + 1'b1;
              launch <= 1'b1;
            end
          end
        end
        S_DT: begin
          if (mac_done) begin
            q_val  <= mac_acc[63:0];
            launch <= 1'b1;
            state  <= S_YAW;
          end
        end
        S_YAW: begin
          if (mac_done) begin
            yaw   <= yaw + mac_acc[63:32];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // hold the result valid until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // load the result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_yaw  <= yaw;
      out_rate <= y_val;
      out_cal  <= was_cal;
      out_bias <= bias;
    end
  end

  assign sample.ready         = (state == S_IDLE);
  assign result.valid         = out_valid;
  assign result.yaw_angle     = out_yaw;
  assign result.filtered_rate = out_rate;
  assign result.calibrating   = out_cal;
  assign result.bias_value    = out_bias;

  `GYI_ASSERT_IMP(a_mac_no_restart, mac_cmd.start, !mac_busy,
                  "multiply-accumulate started while busy")
  `GYI_ASSERT_IMP(a_cal_rate_zero, result.valid && result.calibrating,
                  result.filtered_rate == '0, "nonzero rate during calibration")
  `GYI_ASSERT_IMP(a_cal_done_count, !cal_active, cal_count >= CNT_W'(CAL_SAMPLES),
                  "calibration ended early")
  `GYI_ASSERT_NXT(a_out_hold, result.valid && !result.ready,
                  result.valid && $stable(result.yaw_angle), "result lost on stall")

endmodule

`default_nettype wire

// ===== bench/gyro_yaw_integrator_tb.sv =====
// ----------------------------------------------------------------------------
// Gyro yaw integrator testbench
// Drives gyro samples through the sample channel and checks every result
// transaction against a cycle-free predictor of calibration, band-pass
// filtering and yaw integration. Coefficients are rewritten between phases,
// and both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gyro_yaw_integrator_tb;
  import gyi_pkg::*;

  localparam longint RAD_SCALE   = 64'sd74960064;
  localparam longint YAW_SCALE   = 64'sd44798134;
  localparam longint FIRST_DT    = 64'sd10000;
  localparam int     CAL_COUNT   = 100;
  localparam int     CYCLE_LIMIT = 4000000;
  localparam int     SETTLE      = 400;

  typedef struct {
    logic signed [31:0] rate;
    logic [31:0]        stamp;
  } gyro_sample_t;

  typedef struct {
    logic signed [31:0] yaw;
    logic signed [31:0] filt;
    logic               cal;
    logic signed [31:0] bias;
  } yaw_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  gyi_sample_if smp ();
  gyi_result_if res ();

  gyro_yaw_integrator u_top (
    .clk       (clk),
    .rst       (rst),
    .sample    (smp),
    .result    (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] coefs [NUM_COEF];
  logic signed [31:0] x_hist [HIST];
  logic signed [31:0] y_hist [HIST];
  logic [31:0]        yaw_acc;
  logic signed [31:0] bias_est;
  longint             cal_sum;
  int                 cal_cnt;
  bit                 cal_on;
  bit                 first_seen;
  logic [31:0]        prev_stamp;

  gyro_sample_t pending_samples [$];
  yaw_result_t  expected_yaw [$];
  bit           in_taken = 1'b0;
  int           send_idle_pct = 0;
  int           rx_stall_pct = 0;
  int           rx_hold = 0;
  int           errors = 0;
  int           checked = 0;
  int           yaw_held = 0;
  int           settings = 1;
  int           cycles = 0;
  logic [31:0]  ts_now = '0;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // accumulate one Q36.28 product split into its whole part and 28 fraction bits
  function automatic void mac_acc(inout longint hi, inout longint lo,
                                  input longint a, input longint b, input bit neg);
    longint p;
    p = a * b;
    if (neg) p = -p;
    hi += p >>> FRAC;
    lo += p & ((64'sd1 <<< FRAC) - 1);
  endfunction

  function automatic yaw_result_t predict_yaw(input gyro_sample_t s);
    yaw_result_t        e;
    longint             r, x, hi, lo, tot, dt, q, qh, inc, m;
    longint unsigned    ql;
    logic signed [31:0] y;
    bit                 was_cal;
    r = ((-longint'(s.rate)) * RAD_SCALE + (64'sd1 <<< 31)) >>> 32;
    y = '0;
    was_cal = cal_on;
    if (cal_on) begin
      cal_sum += r;
      cal_cnt++;
      if (cal_cnt >= CAL_COUNT) begin
        if (cal_sum >= 0) m = (cal_sum + CAL_COUNT / 2) / CAL_COUNT;
        else m = -((-cal_sum + CAL_COUNT / 2) / CAL_COUNT);
        bias_est = clamp32(m);
        cal_on = 1'b0;
      end
    end else begin
      x = r - longint'(bias_est);
      hi = 0;
      lo = 0;
      mac_acc(hi, lo, coefs[0], x, 1'b0);
      mac_acc(hi, lo, coefs[1], x_hist[1], 1'b0);
      mac_acc(hi, lo, coefs[2], x_hist[3], 1'b0);
      for (int i = 0; i < HIST; i++) mac_acc(hi, lo, coefs[3 + i], y_hist[i], 1'b1);
      lo += 64'sd1 <<< (FRAC - 1);
      tot = hi + (lo >>> FRAC);
      y = clamp32(tot);
      for (int i = HIST - 1; i > 0; i--) begin
        x_hist[i] = x_hist[i - 1];
        y_hist[i] = y_hist[i - 1];
      end
      x_hist[0] = clamp32(x);
      y_hist[0] = y;
      if (first_seen) begin
        dt = FIRST_DT;
        first_seen = 1'b0;
      end else begin
        dt = longint'($signed(s.stamp - prev_stamp));
      end
      prev_stamp = s.stamp;
      if (dt > 0) begin
        q = longint'(y) * dt;
        qh = q >>> 32;
        ql = longint'(q[31:0]);
        inc = qh * YAW_SCALE + longint'((ql * 64'd44798134 + 64'd2147483648) >> 32);
        yaw_acc = yaw_acc + inc[31:0];
      end else begin
        yaw_held++;
      end
    end
    e.yaw = yaw_acc;
    e.filt = y;
    e.cal = was_cal;
    e.bias = bias_est;
    return e;
  endfunction

  // accept samples and results at the rising edge, check results in order
  always @(posedge clk) begin
    yaw_result_t e;
    gyro_sample_t s;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end else if (!rst) begin
      if (smp.valid && smp.ready) begin
        s.rate = smp.gyro_rate;
        s.stamp = smp.time_stamp;
        e = predict_yaw(s);
        expected_yaw.insert(expected_yaw.size(), e);
        in_taken = 1'b1;
      end
      if (res.valid && res.ready) begin
        if (expected_yaw.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transaction yaw=%0d", $time, res.yaw_angle);
        end else begin
          e = expected_yaw.pop_front();
          checked++;
          if (res.yaw_angle !== e.yaw || res.filtered_rate !== e.filt ||
              res.calibrating !== e.cal || res.bias_value !== e.bias) begin
            errors++;
            $display("%0t: mismatch exp yaw=%0d filt=%0d cal=%0b bias=%0d", $time,
                     e.yaw, e.filt, e.cal, e.bias);
            $display("%0t:          got yaw=%0d filt=%0d cal=%0b bias=%0d", $time,
                     res.yaw_angle, res.filtered_rate, res.calibrating, res.bias_value);
          end
        end
      end
    end
  end

  // sample driver: hold an offered transaction until taken
  always @(negedge clk) begin
    gyro_sample_t s;
    if (rst) begin
      smp.valid <= 1'b0;
    end else if (!smp.valid || in_taken) begin
      in_taken = 1'b0;
      if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s = pending_samples.pop_front();
        smp.valid <= 1'b1;
        smp.gyro_rate <= s.rate;
        smp.time_stamp <= s.stamp;
      end else begin
        smp.valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic push_sample(input logic signed [31:0] rate, input logic [31:0] stamp);
    gyro_sample_t s;
    s.rate = rate;
    s.stamp = stamp;
    pending_samples.insert(pending_samples.size(), s);
    ts_now = stamp;
  endtask

  // mostly plausible rates and steady clocks, some wide and odd cases
  task automatic push_random_sample();
    int                 pick;
    logic signed [31:0] rate;
    logic [31:0]        stamp;
    pick = $urandom_range(99);
    if (pick < 60) rate = $signed($urandom_range(26214400)) - 32'sd13107200;
    else if (pick < 90) rate = $urandom;
    else if (pick < 95) rate = 32'sh7FFFFFFF - $urandom_range(3);
    else rate = 32'sh80000000 + $urandom_range(3);
    pick = $urandom_range(99);
    if (pick < 80) stamp = ts_now + $urandom_range(20000, 1);
    else if (pick < 88) stamp = ts_now;
    else if (pick < 95) stamp = ts_now - $urandom_range(100000, 1);
    else stamp = $urandom;
    push_sample(rate, stamp);
  endtask

  // let every queued transaction through, then pause for the pipeline
  task automatic drain();
    while (pending_samples.size() != 0 || smp.valid || expected_yaw.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_coef(input reg_idx_t idx, input logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    if (idx != REG_NONE) coefs[int'(idx)] = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] b0, b2, b4, a1, a2, a3, a4);
    write_coef(REG_B0, b0);
    write_coef(REG_B2, b2);
    write_coef(REG_B4, b4);
    write_coef(REG_A1, a1);
    write_coef(REG_A2, a2);
    write_coef(REG_A3, a3);
    write_coef(REG_A4, a4);
    settings++;
  endtask

  task automatic random_phase(input int n, input int snd, input int rx);
    send_idle_pct = snd;
    rx_stall_pct = rx;
    repeat (n) push_random_sample();
    drain();
  endtask

  initial begin
    coefs = '{32'sd12509092, -32'sd25018184, 32'sd12509092, -32'sd834780581,
              32'sd993103813, -32'sd538588899, 32'sd115588308};
    foreach (x_hist[i]) begin
      x_hist[i] = '0;
      y_hist[i] = '0;
    end
    yaw_acc = '0;
    bias_est = '0;
    cal_sum = 0;
    cal_cnt = 0;
    cal_on = 1'b1;
    first_seen = 1'b1;
    prev_stamp = '0;
    smp.valid = 1'b0;
    smp.gyro_rate = '0;
    smp.time_stamp = '0;
    res.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // calibration with rate extremes inside, timestamps ignored
    push_sample(32'sh7FFFFFFF, 32'hFFFFFFFF);
    push_sample(32'sh80000000, 32'h0);
    push_sample(32'sh0, 32'h12345678);
    push_sample(-32'sd1, 32'h0);
    repeat (CAL_COUNT - 4) push_sample($signed($urandom_range(655360)) - 32'sd327680, $urandom);
    ts_now = 32'h00001000;
    drain();

    // first filtered sample uses a fixed step; then zero, backward, wrap, extremes
    push_sample(32'sh7FFFFFFF, 32'h00001000);
    push_sample(32'sh80000000, 32'h00001000);
    push_sample(32'sh80000000, 32'h00000800);
    push_sample(32'sh7FFFFFFF, 32'h00002800);
    push_sample(32'sh0, 32'hFFFFFF00);
    push_sample(32'sh00640000, 32'h00000100);
    push_sample(-32'sd1, 32'h80000100);
    push_sample(32'sh00010000, 32'h80000101);
    push_sample(32'sh7FFFFFFF, 32'h000000FF);
    push_sample(32'sh80000000, 32'h7FFFFFFE);
    push_sample(-32'sd6553600, 32'h7FFFFFFF);
    push_sample(32'sd6553600, 32'h80002000);
    push_sample(32'sh55555555, 32'h80004000);
    push_sample(32'shAAAAAAAA, 32'h80006000);
    push_sample(32'sh0, 32'h80008000);
    push_sample(32'sh0, 32'h8000A000);
    push_sample(32'sh7FFFFFFF, 32'h8000C000);
    push_sample(32'sh7FFFFFFF, 32'h8000E000);
    push_sample(32'sh80000000, 32'h80010000);
    push_sample(32'sh80000000, 32'h80012000);
    drain();

    random_phase(300, 0, 0);

    write_all(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    random_phase(150, 74, 0);

    // long receiver hold-off so the block backs up and stalls its input
    write_all(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h80000000);
    rx_hold = 3000;
    random_phase(150, 0, 74);

    write_all('0, '0, '0, '0, '0, '0, '0);
    write_coef(REG_NONE, 32'hDEADBEEF);
    random_phase(100, 31, 31);

    write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    random_phase(80, 0, 74);
    random_phase(80, 74, 0);
    random_phase(90, 31, 31);

    write_all(32'sd12509092, -32'sd25018184, 32'sd12509092, -32'sd834780581,
              32'sd993103813, -32'sd538588899, 32'sd115588308);
    random_phase(120, 0, 0);
    random_phase(120, 74, 0);
    random_phase(120, 0, 74);
    random_phase(120, 31, 31);

    repeat (SETTLE) @(posedge clk);
    $display("checked %0d result transactions over %0d coefficient settings",
             checked, settings);
    $display("yaw held on %0d non-positive steps, %0d errors", yaw_held, errors);
    if (errors == 0 && expected_yaw.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
